// ===== rtl/ffba_pkg.sv =====
`default_nettype none

package ffba_pkg;

    // table geometry
    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int ALIGN_BYTES  = 8;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

    // field widths
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 24;
    localparam int ITEM_W   = 16;
    localparam int LIMIT_W  = 25;
    localparam int WANT_W   = SIZE_W + ITEM_W;
    localparam int NEED_W   = LIMIT_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // largest request that still rounds up inside the size field
    localparam int SIZE_ROUND_MAX = (1 << SIZE_W) - ALIGN_BYTES;
    localparam int LIMIT_RESET    = 1 << SIZE_W;

    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_ARRAY  = 2'd1,
        MODE_FREE   = 2'd2,
        MODE_RESIZE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NULL    = 2'd1,
        ST_NOMEM   = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_BASE  = 2'd0,
        CFG_HEAP_LIMIT = 2'd1
    } t_cfg_reg;

    // one block descriptor
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic              free;
    } t_entry;

    // table write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_entry           data;
    } t_tbl_wr;

endpackage

`default_nettype wire

// ===== rtl/ffba_ifs.sv =====
`default_nettype none

// allocation request channel
interface ffba_req_if;
    import ffba_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          mode;
    logic [SIZE_W-1:0]   request_size;
    logic [ITEM_W-1:0]   item_count;
    logic [ADDR_W-1:0]   block_address;

    modport source (output valid, mode, request_size, item_count, block_address,
                    input ready);
    modport sink   (input valid, mode, request_size, item_count, block_address,
                    output ready);
endinterface

// allocation response channel
interface ffba_rsp_if;
    import ffba_pkg::*;
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   result_address;
    logic [1:0]          status;
    logic [SIZE_W-1:0]   copy_bytes;

    modport source (output valid, result_address, status, copy_bytes, input ready);
    modport sink   (input valid, result_address, status, copy_bytes, output ready);
endinterface

// configuration write channel
interface ffba_cfg_if;
    import ffba_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ffba_table.sv =====
`default_nettype none

module ffba_table (
    input  logic                         i_clk,
    input  ffba_pkg::t_tbl_wr            i_wr,
    input  logic [ffba_pkg::IDX_W-1:0]   i_rd_idx,
    output ffba_pkg::t_entry             o_rd_data
);
    import ffba_pkg::*;

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rd_data;

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
`default_nettype none
// an allocate scans the block table for a fit, a free scans it for the address,
// and a resize that moves the block scans it twice (address search, then fit search)
// throughput: one request at a time, set by the one-entry-per-cycle scan of the block table
// the response register lets a new request enter while the previous response waits
// reset: block count, used bytes and configuration return to their reset values;
// table contents are left as they are, only entries below the block count are ever read

module first_fit_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffba_req_if.sink    i_req,
    ffba_rsp_if.source  o_rsp,
    ffba_cfg_if.sink    i_cfg
);
    import ffba_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PREP   = 8'b0000_0010,
        S_EVAL   = 8'b0000_0100,
        S_FIND   = 8'b0000_1000,
        S_ALLOC  = 8'b0001_0000,
        S_WR_NEW = 8'b0010_0000,
        S_WR_OLD = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    // control state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [LIMIT_W-1:0]  r_bytes_used, n_bytes_used;
    logic [CNT_W-1:0]    r_rd_idx, n_rd_idx;
    logic                r_chk_valid, n_chk_valid;
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_base;
    logic [LIMIT_W-1:0]  r_limit;

    // request payload and working values
    logic [1:0]          r_mode;
    logic [SIZE_W-1:0]   r_size;
    logic [ITEM_W-1:0]   r_items;
    logic [ADDR_W-1:0]   r_addr;
    logic [WANT_W-1:0]   r_want;
    logic [SIZE_W-1:0]   r_rounded;
    logic                r_oversize;
    logic [IDX_W-1:0]    r_chk_idx;
    logic                r_move, n_move;
    logic                r_append, n_append;
    logic [IDX_W-1:0]    r_old_idx, n_old_idx;
    logic [ADDR_W-1:0]   r_old_addr, n_old_addr;
    logic [SIZE_W-1:0]   r_old_size, n_old_size;
    logic [IDX_W-1:0]    r_new_idx, n_new_idx;
    t_entry              r_new_entry, n_new_entry;
    logic [NEED_W-1:0]   r_need, n_need;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    t_status             r_res_status, n_res_status;
    logic [SIZE_W-1:0]   r_res_copy, n_res_copy;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [1:0]          r_out_status;
    logic [SIZE_W-1:0]   r_out_copy;

    // table port
    t_tbl_wr             tbl_wr;
    t_entry              rd_data;

    logic                req_fire;
    logic                out_load;
    logic                scanning;
    logic                issue;
    logic                hit_find;
    logic                hit_alloc;
    logic                exhausted;
    logic [SIZE_W:0]     round_sum;
    logic [SIZE_W-1:0]   rounded;
    logic [NEED_W-1:0]   need;
    logic [ADDR_W-1:0]   app_addr;

    ffba_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_idx  (r_rd_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid & i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign out_load    = (r_state == S_DONE) & (~r_out_valid | o_rsp.ready);

    // scan pipeline: read issued one cycle, checked the next
    assign scanning  = (r_state == S_FIND) | (r_state == S_ALLOC);
    assign issue     = r_rd_idx < r_count;
    assign hit_find  = r_chk_valid & (rd_data.addr == r_addr);
    assign hit_alloc = r_chk_valid & rd_data.free & (rd_data.size >= r_rounded);
    assign exhausted = ~r_chk_valid & ~issue;

    // round up to the alignment
    assign round_sum = {1'b0, r_want[SIZE_W-1:0]} + (SIZE_W+1)'(ALIGN_BYTES - 1);
    assign rounded   = round_sum[SIZE_W-1:0] & ~SIZE_W'(ALIGN_BYTES - 1);

    // heap growth for an appended block
    assign need     = NEED_W'(r_bytes_used) + NEED_W'(HEADER_BYTES) + NEED_W'(r_rounded);
    assign app_addr = r_base + ADDR_W'(r_bytes_used) + ADDR_W'(HEADER_BYTES);

    // table writes only in their own states, never during a scan
    always_comb begin
        tbl_wr.en   = (r_state == S_WR_NEW) | (r_state == S_WR_OLD);
        tbl_wr.idx  = r_new_idx;
        tbl_wr.data = r_new_entry;
        if (r_state == S_WR_OLD) begin
            tbl_wr.idx  = r_old_idx;
            tbl_wr.data = '{addr: r_old_addr, size: r_old_size, free: 1'b1};
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_bytes_used = r_bytes_used;
        n_rd_idx     = r_rd_idx;
        n_chk_valid  = 1'b0;
        n_move       = r_move;
        n_append     = r_append;
        n_old_idx    = r_old_idx;
        n_old_addr   = r_old_addr;
        n_old_size   = r_old_size;
        n_new_idx    = r_new_idx;
        n_new_entry  = r_new_entry;
        n_need       = r_need;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_res_copy   = r_res_copy;

        // keep reads streaming while scanning
        if (scanning && issue) begin
            n_rd_idx    = r_rd_idx + CNT_W'(1);
            n_chk_valid = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_move       = 1'b0;
                n_append     = 1'b0;
                n_rd_idx     = '0;
                n_res_addr   = '0;
                n_res_copy   = '0;
                n_res_status = ST_OK;
                if (r_mode == MODE_FREE || (r_mode == MODE_RESIZE && r_addr != '0)) begin
                    if (r_addr == '0) begin
                        n_res_status = ST_NULL;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_FIND;
                    end
                end else if (r_want == '0) begin
                    n_res_status = ST_NULL;
                    n_state      = S_DONE;
                end else if (r_want > WANT_W'(SIZE_ROUND_MAX)) begin
                    n_res_status = ST_NOMEM;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_ALLOC;
                end
            end
            S_FIND: begin
                if (hit_find) begin
                    n_chk_valid = 1'b0;
                    n_old_idx   = r_chk_idx;
                    n_old_addr  = rd_data.addr;
                    n_old_size  = rd_data.size;
                    if (r_mode == MODE_FREE) begin
                        n_res_status = ST_OK;
                        n_state      = S_WR_OLD;
                    end else if (r_size == '0) begin
                        n_res_status = ST_NULL;
                        n_state      = S_WR_OLD;
                    end else if (rd_data.size >= r_size) begin
                        n_res_addr   = r_addr;
                        n_res_status = ST_OK;
                        n_state      = S_DONE;
                    end else if (r_oversize) begin
                        n_res_status = ST_NOMEM;
                        n_state      = S_DONE;
                    end else begin
                        n_move   = 1'b1;
                        n_rd_idx = '0;
                        n_state  = S_ALLOC;
                    end
                end else if (exhausted) begin
                    n_res_status = ST_UNKNOWN;
                    n_state      = S_DONE;
                end
            end
            S_ALLOC: begin
                // a block granted at address zero reads as no memory, the old block stays
                if (hit_alloc) begin
                    n_chk_valid  = 1'b0;
                    n_new_idx    = r_chk_idx;
                    n_new_entry  = '{addr: rd_data.addr, size: rd_data.size, free: 1'b0};
                    n_append     = 1'b0;
                    n_res_addr   = rd_data.addr;
                    n_res_status = (rd_data.addr == '0) ? ST_NOMEM : ST_OK;
                    n_res_copy   = (r_move && rd_data.addr != '0) ? r_old_size : '0;
                    n_state      = S_WR_NEW;
                end else if (exhausted) begin
                    if (r_count == CNT_W'(MAX_BLOCKS) || need > NEED_W'(r_limit)) begin
                        // no room: old block of a resize stays as it is
                        n_res_addr   = '0;
                        n_res_status = ST_NOMEM;
                        n_res_copy   = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_new_idx    = r_count[IDX_W-1:0];
                        n_new_entry  = '{addr: app_addr, size: r_rounded, free: 1'b0};
                        n_append     = 1'b1;
                        n_need       = need;
                        n_res_addr   = app_addr;
                        n_res_status = (app_addr == '0) ? ST_NOMEM : ST_OK;
                        n_res_copy   = (r_move && app_addr != '0) ? r_old_size : '0;
                        n_state      = S_WR_NEW;
                    end
                end
            end
            S_WR_NEW: begin
                if (r_append) begin
                    n_count      = r_count + CNT_W'(1);
                    n_bytes_used = r_need[LIMIT_W-1:0];
                end
                n_state = (r_move && r_res_addr != '0) ? S_WR_OLD : S_DONE;
            end
            S_WR_OLD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_bytes_used <= '0;
            r_rd_idx     <= '0;
            r_chk_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_base       <= '0;
            r_limit      <= LIMIT_W'(LIMIT_RESET);
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_bytes_used <= n_bytes_used;
            r_rd_idx     <= n_rd_idx;
            r_chk_valid  <= n_chk_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            // configuration writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_HEAP_BASE:  r_base  <= i_cfg.data;
                    CFG_HEAP_LIMIT: r_limit <= i_cfg.data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_mode  <= i_req.mode;
            r_size  <= i_req.request_size;
            r_items <= i_req.item_count;
            r_addr  <= i_req.block_address;
        end
        // array product, registered before rounding
        if (r_state == S_PREP) begin
            r_want <= (r_mode == MODE_ARRAY) ? WANT_W'(r_size) * WANT_W'(r_items)
                                             : WANT_W'(r_size);
        end
        if (r_state == S_EVAL) begin
            r_rounded  <= rounded;
            r_oversize <= r_want > WANT_W'(SIZE_ROUND_MAX);
        end
        r_chk_idx    <= r_rd_idx[IDX_W-1:0];
        r_move       <= n_move;
        r_append     <= n_append;
        r_old_idx    <= n_old_idx;
        r_old_addr   <= n_old_addr;
        r_old_size   <= n_old_size;
        r_new_idx    <= n_new_idx;
        r_new_entry  <= n_new_entry;
        r_need       <= n_need;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_res_copy   <= n_res_copy;
        if (out_load) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
            r_out_copy   <= r_res_copy;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_address = r_out_addr;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.copy_bytes     = r_out_copy;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("block count above table depth");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR_NEW && r_append) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("append did not advance block count");

    a_check_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_valid |-> (r_state == S_FIND || r_state == S_ALLOC))
        else $error("scan check outside a scan");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND || r_state == S_ALLOC) |-> (r_rd_idx <= r_count))
        else $error("scan read past last block");

endmodule

`default_nettype wire

// ===== tb/tb_first_fit_block_allocator.sv =====
module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [63:0] SIZE_FIELD_MAX = (64'd1 << SIZE_W) - 64'd1;
    localparam logic [31:0] LIMIT_FULL     = 32'd16777216;

    typedef struct packed {
        t_mode             mode;
        logic [SIZE_W-1:0] size;
        logic [ITEM_W-1:0] count;
        logic [ADDR_W-1:0] addr;
    } t_heap_req;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        t_status           status;
        logic [SIZE_W-1:0] copy;
    } t_heap_answer;

    typedef struct {
        t_heap_req    req;
        bit           typed;
        t_heap_answer answer;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    ffba_req_if req_if ();
    ffba_rsp_if rsp_if ();
    ffba_cfg_if cfg_if ();

    first_fit_block_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // mirror of the block table and heap registers
    logic [ADDR_W-1:0] blk_addr [MAX_BLOCKS];
    logic [SIZE_W-1:0] blk_size [MAX_BLOCKS];
    bit                blk_free [MAX_BLOCKS];
    int                blk_count;
    int                blk_peak;
    logic [63:0]       heap_used;
    logic [31:0]       heap_base;
    logic [63:0]       heap_limit;

    t_heap_answer pending_answers [$];
    t_script_row  script [$];

    int mismatches;
    int stall_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int cfg_writes;
    int mode_hits [4];
    int status_hits [4];

    // clock
    always #HALF_PERIOD i_clk = ~i_clk;

    // first free block that fits, else append at the break; 0 means no room
    function automatic logic [31:0] claim_block(input logic [63:0] want);
        logic [63:0] rounded;
        logic [63:0] need;
        logic [31:0] fresh;
        rounded = (want + 64'd7) & ~64'd7;
        if (rounded > SIZE_FIELD_MAX)
            return '0;
        for (int i = 0; i < blk_count; i++) begin
            if (blk_free[i] && 64'(blk_size[i]) >= rounded) begin
                blk_free[i] = 1'b0;
                return blk_addr[i];
            end
        end
        if (blk_count >= MAX_BLOCKS)
            return '0;
        need = heap_used + 64'(HEADER_BYTES) + rounded;
        if (need > heap_limit)
            return '0;
        fresh = heap_base + heap_used[31:0] + 32'(HEADER_BYTES);
        blk_addr[blk_count] = fresh;
        blk_size[blk_count] = rounded[SIZE_W-1:0];
        blk_free[blk_count] = 1'b0;
        blk_count++;
        if (blk_count > blk_peak)
            blk_peak = blk_count;
        heap_used = need;
        return fresh;
    endfunction

    function automatic int locate_block(input logic [31:0] a);
        for (int i = 0; i < blk_count; i++) begin
            if (blk_addr[i] == a)
                return i;
        end
        return -1;
    endfunction

    // allocation answer for a byte count, zero gives a null answer
    function automatic t_heap_answer grant_answer(input logic [63:0] want);
        t_heap_answer ans;
        logic [31:0]  a;
        ans.addr   = '0;
        ans.status = ST_NULL;
        ans.copy   = '0;
        if (want != 64'd0) begin
            a = claim_block(want);
            ans.addr = a;
            if (a != '0)
                ans.status = ST_OK;
            else
                ans.status = ST_NOMEM;
        end
        return ans;
    endfunction

    // expected answer for one request, updates the mirrored table
    function automatic t_heap_answer heap_answer(input t_heap_req r);
        t_heap_answer      ans;
        int                slot;
        logic [31:0]       moved;
        logic [SIZE_W-1:0] old_size;
        ans.addr   = '0;
        ans.status = ST_OK;
        ans.copy   = '0;
        slot = locate_block(r.addr);
        case (r.mode)
            MODE_ALLOC: begin
                ans = grant_answer(64'(r.size));
            end
            MODE_ARRAY: begin
                ans = grant_answer(64'(r.size) * 64'(r.count));
            end
            MODE_FREE: begin
                if (r.addr == '0)
                    ans.status = ST_NULL;
                else if (slot < 0)
                    ans.status = ST_UNKNOWN;
                else
                    blk_free[slot] = 1'b1;
            end
            default: begin
                if (r.addr == '0) begin
                    ans = grant_answer(64'(r.size));
                end else if (slot < 0) begin
                    ans.status = ST_UNKNOWN;
                end else if (r.size == '0) begin
                    blk_free[slot] = 1'b1;
                    ans.status = ST_NULL;
                end else if (blk_size[slot] >= r.size) begin
                    ans.addr = r.addr;
                end else begin
                    old_size = blk_size[slot];
                    moved = claim_block(64'(r.size));
                    if (moved == '0) begin
                        ans.status = ST_NOMEM;
                    end else begin
                        blk_free[slot] = 1'b1;
                        ans.addr = moved;
                        ans.copy = old_size;
                    end
                end
            end
        endcase
        return ans;
    endfunction

    function automatic void add_row(input t_mode m, input logic [23:0] size,
                                    input logic [15:0] count, input logic [31:0] addr,
                                    input bit typed, input logic [31:0] exp_addr,
                                    input t_status exp_status);
        t_script_row row;
        row.req.mode      = m;
        row.req.size      = size;
        row.req.count     = count;
        row.req.addr      = addr;
        row.typed         = typed;
        row.answer.addr   = exp_addr;
        row.answer.status = exp_status;
        row.answer.copy   = '0;
        script.push_back(row);
    endfunction

    // mostly small sizes, now and then anything the field holds
    function automatic logic [23:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 24'($urandom_range(0, 64));
        else if (roll < 90)
            return 24'($urandom_range(0, 4096));
        else
            return 24'($urandom());
    endfunction

    // live block addresses most of the time, else null or noise
    function automatic logic [31:0] pick_address();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85 && blk_count > 0)
            return blk_addr[$urandom_range(0, blk_count - 1)];
        else if (roll < 90)
            return '0;
        else
            return 32'($urandom());
    endfunction

    function automatic t_heap_req random_request();
        t_heap_req r;
        int        roll;
        r.size  = pick_size();
        r.count = 16'($urandom());
        r.addr  = 32'($urandom());
        roll = $urandom_range(99);
        if (roll < 40) begin
            r.mode = MODE_ALLOC;
        end else if (roll < 50) begin
            r.mode = MODE_ARRAY;
            if ($urandom_range(99) < 80) begin
                r.size  = 24'($urandom_range(0, 64));
                r.count = 16'($urandom_range(0, 8));
            end
        end else if (roll < 75) begin
            r.mode = MODE_FREE;
            r.addr = pick_address();
        end else begin
            r.mode = MODE_RESIZE;
            r.addr = pick_address();
            if ($urandom_range(99) < 10)
                r.size = '0;
        end
        return r;
    endfunction

    // present one request and hold it until accepted
    task automatic issue_request(input t_heap_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.mode          <= r.mode;
        req_if.request_size  <= r.size;
        req_if.item_count    <= r.count;
        req_if.block_address <= r.addr;
        do @(posedge i_clk); while (!req_if.ready);
        mode_hits[r.mode]++;
    endtask

    // hold off requests until every answer is back
    task automatic wait_drain();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_answers.size() != 0);
    endtask

    task automatic program_heap(input logic [31:0] base, input logic [31:0] limit);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_HEAP_BASE;
        cfg_if.data  <= base;
        do @(posedge i_clk); while (!cfg_if.ready);
        heap_base = base;
        cfg_if.index <= CFG_HEAP_LIMIT;
        cfg_if.data  <= limit;
        do @(posedge i_clk); while (!cfg_if.ready);
        heap_limit = 64'(limit[LIMIT_W-1:0]);
        cfg_if.valid <= 1'b0;
        cfg_writes += 2;
    endtask

    task automatic run_random_phase(input int n);
        t_heap_req r;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 59) == 0)
                wait_drain();
            r = random_request();
            issue_request(r);
            pending_answers.push_back(heap_answer(r));
        end
    endtask

    // response side back-pressure
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each answer with the oldest expectation
    always @(posedge i_clk) begin
        t_heap_answer exp_ans;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t unexpected answer: expected none actual addr %h status %0d copy %h",
                         $time, rsp_if.result_address, rsp_if.status, rsp_if.copy_bytes);
                mismatches++;
            end else begin
                exp_ans = pending_answers.pop_front();
                status_hits[exp_ans.status]++;
                if (rsp_if.result_address !== exp_ans.addr) begin
                    $display("%0t result_address mismatch: expected %h actual %h",
                             $time, exp_ans.addr, rsp_if.result_address);
                    mismatches++;
                end
                if (rsp_if.status !== exp_ans.status) begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, exp_ans.status, rsp_if.status);
                    mismatches++;
                end
                if (rsp_if.copy_bytes !== exp_ans.copy) begin
                    $display("%0t copy_bytes mismatch: expected %h actual %h",
                             $time, exp_ans.copy, rsp_if.copy_bytes);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("first_fit_block_allocator regression: fail");
            $finish;
        end
    end

    // main sequence
    initial begin
        t_heap_answer ans;
        t_script_row  row;
        logic [63:0]  tight_limit;
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.mode          = MODE_ALLOC;
        req_if.request_size  = '0;
        req_if.item_count    = '0;
        req_if.block_address = '0;
        rsp_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_HEAP_BASE;
        cfg_if.data          = '0;
        mismatches           = 0;
        stall_cycles         = 0;
        cfg_writes           = 0;
        blk_count            = 0;
        blk_peak             = 0;
        heap_used            = '0;
        heap_base            = '0;
        heap_limit           = 64'(LIMIT_FULL);
        send_idle_pct        = 24;
        recv_idle_pct        = 47;
        foreach (mode_hits[i]) mode_hits[i] = 0;
        foreach (status_hits[i]) status_hits[i] = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass on reset settings: base 0, full limit
        add_row(MODE_ALLOC,  24'd0,        16'd0,     32'd0,        1, 32'd0,  ST_NULL);
        add_row(MODE_ALLOC,  24'd1,        16'd0,     32'd0,        1, 32'd24, ST_OK);
        add_row(MODE_ALLOC,  24'd16,       16'd0,     32'd0,        1, 32'd56, ST_OK);
        add_row(MODE_ARRAY,  24'hFF_FFFF,  16'd0,     32'd0,        1, 32'd0,  ST_NULL);
        add_row(MODE_ARRAY,  24'd0,        16'hFFFF,  32'd0,        1, 32'd0,  ST_NULL);
        add_row(MODE_ARRAY,  24'd5,        16'd3,     32'd0,        1, 32'd96, ST_OK);
        add_row(MODE_ALLOC,  24'hFF_FFFF,  16'hFFFF,  32'hFFFF_FFFF, 1, 32'd0, ST_NOMEM);
        add_row(MODE_ALLOC,  24'hFF_FFF8,  16'd0,     32'd0,        1, 32'd0,  ST_NOMEM);
        add_row(MODE_ARRAY,  24'hFF_FFFF,  16'hFFFF,  32'd0,        1, 32'd0,  ST_NOMEM);
        add_row(MODE_FREE,   24'd0,        16'd0,     32'd0,        1, 32'd0,  ST_NULL);
        add_row(MODE_FREE,   24'hFF_FFFF,  16'd0,     32'hFFFF_FFFF, 1, 32'd0, ST_UNKNOWN);
        add_row(MODE_FREE,   24'd0,        16'd0,     32'd24,       1, 32'd0,  ST_OK);
        add_row(MODE_FREE,   24'd0,        16'd0,     32'd24,       1, 32'd0,  ST_OK);
        add_row(MODE_ALLOC,  24'd8,        16'd0,     32'd0,        0, 32'd0,  ST_OK);
        add_row(MODE_FREE,   24'd0,        16'd0,     32'd56,       1, 32'd0,  ST_OK);
        add_row(MODE_RESIZE, 24'd10,       16'd0,     32'd56,       0, 32'd0,  ST_OK);
        add_row(MODE_RESIZE, 24'd3,        16'd0,     32'd0,        0, 32'd0,  ST_OK);
        add_row(MODE_RESIZE, 24'd0,        16'd0,     32'd56,       1, 32'd0,  ST_NULL);
        add_row(MODE_RESIZE, 24'd4,        16'd0,     32'h1234_5678, 1, 32'd0, ST_UNKNOWN);
        add_row(MODE_RESIZE, 24'd100,      16'd0,     32'd96,       0, 32'd0,  ST_OK);
        add_row(MODE_RESIZE, 24'hFF_FFFF,  16'd0,     32'd136,      0, 32'd0,  ST_OK);
        add_row(MODE_RESIZE, 24'd8,        16'd0,     32'd24,       0, 32'd0,  ST_OK);
        add_row(MODE_ARRAY,  24'd1,        16'hFFFF,  32'd0,        0, 32'd0,  ST_OK);
        add_row(MODE_RESIZE, 24'd0,        16'd0,     32'd0,        1, 32'd0,  ST_NULL);

        foreach (script[i]) begin
            row = script[i];
            issue_request(row.req);
            ans = heap_answer(row.req);
            if (row.typed)
                pending_answers.push_back(row.answer);
            else
                pending_answers.push_back(ans);
        end
        wait_drain();

        // top of the address space, addresses wrap
        program_heap(32'hFFFF_FFFF, LIMIT_FULL);
        run_random_phase(60);
        wait_drain();

        // no room above the break at all
        program_heap(32'($urandom()), 32'd0);
        run_random_phase(20);
        wait_drain();

        // tight limit just above the current break, idling swapped
        tight_limit = heap_used + 64'($urandom_range(0, 6000));
        if (tight_limit > 64'(LIMIT_FULL))
            tight_limit = 64'(LIMIT_FULL);
        send_idle_pct = 47;
        recv_idle_pct = 24;
        program_heap(32'($urandom()), tight_limit[31:0]);
        run_random_phase(150);
        wait_drain();

        // base zero, random limit, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_heap(32'd0, 32'($urandom_range(0, LIMIT_FULL)));
        run_random_phase(200);
        wait_drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run: %0d requests (alloc %0d, array %0d, free %0d, resize %0d), %0d reg writes",
                 mode_hits[0] + mode_hits[1] + mode_hits[2] + mode_hits[3],
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], cfg_writes);
        $display("answers: ok %0d, null %0d, no memory %0d, unknown %0d; table peak %0d blocks",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3], blk_peak);
        if (mismatches == 0) begin
            $display("first_fit_block_allocator regression: pass");
        end else begin
            $display("first_fit_block_allocator regression: fail");
        end
        $finish;
    end

endmodule
